// File: hdl/jfhs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JPEG frame header scanner - shared definitions
// Phase codes, marker bytes, status codes, register indexes and reset values
// used by the scanner top level and its parser.
// ----------------------------------------------------------------------------
package jfhs_pkg;

    localparam int JFH_MAX_FILE_BYTES = 1048576;

    localparam int FILE_LEN_W = 21;
    localparam int DIM_W      = 16;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;

    localparam logic [FILE_LEN_W-1:0] RST_FILE_LENGTH = 21'd1048576;
    localparam logic [DIM_W-1:0]      RST_MAX_WIDTH   = 16'd320;
    localparam logic [DIM_W-1:0]      RST_MAX_HEIGHT  = 16'd320;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_JPEG     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_LENGTH   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_BASELINE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_HEADER    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE    = 3'd5;

    // Marker bytes
    localparam logic [7:0] MK_FILL  = 8'hFF;
    localparam logic [7:0] MK_STUFF = 8'h00;
    localparam logic [7:0] MK_SOI   = 8'hD8;
    localparam logic [7:0] MK_EOI   = 8'hD9;
    localparam logic [7:0] MK_SOS   = 8'hDA;
    localparam logic [7:0] MK_RST0  = 8'hD0;
    localparam logic [7:0] MK_RST7  = 8'hD7;
    localparam logic [7:0] MK_SOF0  = 8'hC0;
    localparam logic [7:0] MK_SOF15 = 8'hCF;
    localparam logic [7:0] MK_DHT   = 8'hC4;
    localparam logic [7:0] MK_JPG   = 8'hC8;
    localparam logic [7:0] MK_DAC   = 8'hCC;

    typedef enum logic [12:0] {
        PH_START0 = 13'b0000000000001,
        PH_START1 = 13'b0000000000010,
        PH_SEEK   = 13'b0000000000100,
        PH_FILL   = 13'b0000000001000,
        PH_LEN_HI = 13'b0000000010000,
        PH_LEN_LO = 13'b0000000100000,
        PH_SKIP   = 13'b0000001000000,
        PH_PREC   = 13'b0000010000000,
        PH_H_HI   = 13'b0000100000000,
        PH_H_LO   = 13'b0001000000000,
        PH_W_HI   = 13'b0010000000000,
        PH_W_LO   = 13'b0100000000000,
        PH_DRAIN  = 13'b1000000000000
    } t_phase;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
    } t_result;

    // Start-of-frame markers: C0..CF less DHT, JPG and DAC
    function automatic logic is_sof(input logic [7:0] marker);
        is_sof = (marker >= MK_SOF0) && (marker <= MK_SOF15) &&
                 (marker != MK_DHT) && (marker != MK_JPG) && (marker != MK_DAC);
    endfunction

endpackage
`default_nettype wire

// File: hdl/jfhs_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JPEG frame header scanner - byte parser
// Marker scan state machine, file position tracking and size checks. One
// byte is consumed per accepted item; a result, if any, is flagged in the
// same cycle for the output register to capture.
// ----------------------------------------------------------------------------
module jfhs_parser
    import jfhs_pkg::*;
#(
    parameter int MAX_FILE_BYTES = JFH_MAX_FILE_BYTES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic [FILE_LEN_W-1:0] i_file_length,
    input  wire logic [DIM_W-1:0]      i_max_width,
    input  wire logic [DIM_W-1:0]      i_max_height,
    output t_result                    o_result
);

    localparam int LenW = $clog2(MAX_FILE_BYTES + 1);
    localparam int CmpW = (LenW + 1 > DIM_W) ? LenW + 1 : DIM_W;
    localparam logic [31:0] MaxLen = 32'(MAX_FILE_BYTES);

    t_phase                r_phase, n_phase;
    logic [LenW-1:0]       r_pos, n_pos;
    logic [LenW-1:0]       r_len, n_len;
    logic                  r_given, n_given;
    logic [DIM_W-1:0]      r_rem, n_rem;
    logic [7:0]            r_seg_hi, n_seg_hi;
    logic [7:0]            r_marker, n_marker;
    logic [DIM_W-1:0]      r_height, n_height;
    logic [7:0]            r_w_hi, n_w_hi;

    logic [31:0]           len_ext;
    logic [31:0]           len_sat;
    logic [LenW-1:0]       len_cur;
    logic [DIM_W-1:0]      seg_size;
    logic [CmpW-1:0]       room;
    logic [DIM_W-1:0]      rem_dec;
    logic [DIM_W-1:0]      width_cur;
    logic                  last_byte;
    t_result               res;

    always_comb begin
        len_ext   = {{(32 - FILE_LEN_W){1'b0}}, i_file_length};
        len_sat   = (len_ext > MaxLen) ? MaxLen : len_ext;
        len_cur   = (r_pos == '0) ? len_sat[LenW-1:0] : r_len;
        seg_size  = {r_seg_hi, i_data_byte};
        // bytes left from the first length byte to the end of file
        room      = CmpW'({1'b0, len_cur}) - CmpW'({1'b0, r_pos}) + CmpW'(1);
        rem_dec   = (r_rem != '0) ? r_rem - DIM_W'(1) : r_rem;
        width_cur = {r_w_hi, i_data_byte};
        last_byte = ({1'b0, r_pos} + (LenW + 1)'(1)) >= {1'b0, len_cur};

        n_phase  = r_phase;
        n_pos    = r_pos;
        n_len    = r_len;
        n_given  = r_given;
        n_rem    = r_rem;
        n_seg_hi = r_seg_hi;
        n_marker = r_marker;
        n_height = r_height;
        n_w_hi   = r_w_hi;
        res      = '0;

        if (i_accept) begin
            n_len = len_cur;
            unique case (r_phase)
                PH_START0: begin
                    if (len_cur < LenW'(4) || i_data_byte != MK_FILL) begin
                        res.valid  = 1'b1;
                        res.status = ST_NOT_JPEG;
                    end else begin
                        n_phase = PH_START1;
                    end
                end
                PH_START1: begin
                    if (i_data_byte != MK_SOI) begin
                        res.valid  = 1'b1;
                        res.status = ST_NOT_JPEG;
                    end else begin
                        n_phase = PH_SEEK;
                    end
                end
                PH_SEEK: begin
                    if (i_data_byte == MK_FILL) begin
                        n_phase = PH_FILL;
                    end
                end
                PH_FILL: begin
                    priority if (i_data_byte == MK_FILL) begin
                        n_phase = PH_FILL;
                    end else if (i_data_byte == MK_STUFF || i_data_byte == MK_SOI ||
                                 (i_data_byte >= MK_RST0 && i_data_byte <= MK_RST7)) begin
                        n_phase = PH_SEEK;
                    end else if (i_data_byte == MK_EOI || i_data_byte == MK_SOS) begin
                        n_phase = PH_DRAIN;
                    end else begin
                        n_marker = i_data_byte;
                        n_phase  = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    n_seg_hi = i_data_byte;
                    n_phase  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    priority if (seg_size < DIM_W'(2) || CmpW'(seg_size) > room) begin
                        res.valid  = 1'b1;
                        res.status = ST_BAD_LENGTH;
                    end else if (is_sof(r_marker)) begin
                        if (r_marker != MK_SOF0) begin
                            res.valid  = 1'b1;
                            res.status = ST_NOT_BASELINE;
                        end else if (seg_size < DIM_W'(8)) begin
                            res.valid  = 1'b1;
                            res.status = ST_BAD_LENGTH;
                        end else begin
                            n_phase = PH_PREC;
                        end
                    end else begin
                        n_rem   = seg_size - DIM_W'(2);
                        n_phase = (seg_size == DIM_W'(2)) ? PH_SEEK : PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    n_rem = rem_dec;
                    if (rem_dec == '0) begin
                        n_phase = PH_SEEK;
                    end
                end
                PH_PREC: begin
                    n_phase = PH_H_HI;
                end
                PH_H_HI: begin
                    n_height = {i_data_byte, 8'h00};
                    n_phase  = PH_H_LO;
                end
                PH_H_LO: begin
                    n_height = {r_height[15:8], i_data_byte};
                    n_phase  = PH_W_HI;
                end
                PH_W_HI: begin
                    n_w_hi  = i_data_byte;
                    n_phase = PH_W_LO;
                end
                PH_W_LO: begin
                    res.valid = 1'b1;
                    priority if (width_cur == '0 || r_height == '0) begin
                        res.status = ST_BAD_LENGTH;
                    end else if (width_cur > i_max_width || r_height > i_max_height) begin
                        res.status = ST_TOO_LARGE;
                        res.width  = width_cur;
                        res.height = r_height;
                    end else begin
                        res.status = ST_OK;
                        res.width  = width_cur;
                        res.height = r_height;
                    end
                end
                PH_DRAIN: begin
                    n_phase = PH_DRAIN;
                end
                default: begin
                    n_phase = PH_START0;
                end
            endcase

            if (res.valid) begin
                n_given = 1'b1;
                n_phase = PH_DRAIN;
            end

            // end of file: report a missing header, then re-arm
            if (last_byte) begin
                if (!n_given) begin
                    res.valid  = 1'b1;
                    res.status = ST_NO_HEADER;
                end
                n_phase = PH_START0;
                n_pos   = '0;
                n_given = 1'b0;
            end else begin
                n_pos = r_pos + LenW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START0;
            r_pos   <= '0;
            r_len   <= '0;
            r_given <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_given <= n_given;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_seg_hi <= n_seg_hi;
        r_marker <= n_marker;
        r_height <= n_height;
        r_w_hi   <= n_w_hi;
    end

    assign o_result = res;

endmodule
`default_nettype wire

// File: hdl/jpeg_frame_header_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JPEG frame header scanner
// Streams the bytes of a JPEG file and reports the baseline frame size.
// ----------------------------------------------------------------------------
// The scanner takes one file byte per clock cycle with no gaps of its own:
// each byte passes through the marker state machine in the cycle it is
// accepted, and the single result for a file is loaded into an output
// register at the end of that cycle, so o_out_valid rises in the cycle after
// the deciding byte (or after the file's last byte for a missing header).
// The input stalls only while a result sits in the output register and the
// consumer holds i_out_ready low. Set file_length before the first byte of
// each file; it is sampled at that byte and saturated to MAX_FILE_BYTES.
// After the last byte of a file the scanner re-arms by itself for the next.
// ----------------------------------------------------------------------------
module jpeg_frame_header_scanner
    import jfhs_pkg::*;
#(
    parameter int MAX_FILE_BYTES = JFH_MAX_FILE_BYTES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [FILE_LEN_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [7:0]            i_data_byte,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [STATUS_W-1:0]        o_status,
    output logic [DIM_W-1:0]           o_width,
    output logic [DIM_W-1:0]           o_height
);

    logic [FILE_LEN_W-1:0] r_file_length;
    logic [DIM_W-1:0]      r_max_width;
    logic [DIM_W-1:0]      r_max_height;
    logic                  r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]   r_status;
    logic [DIM_W-1:0]      r_width;
    logic [DIM_W-1:0]      r_height;
    logic                  in_accept;
    t_result               w_result;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_length <= RST_FILE_LENGTH;
            r_max_width   <= RST_MAX_WIDTH;
            r_max_height  <= RST_MAX_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FILE_LENGTH: r_file_length <= i_cfg_data;
                CFG_MAX_WIDTH:   r_max_width   <= i_cfg_data[DIM_W-1:0];
                CFG_MAX_HEIGHT:  r_max_height  <= i_cfg_data[DIM_W-1:0];
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    jfhs_parser #(
        .MAX_FILE_BYTES(MAX_FILE_BYTES)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_data_byte   (i_data_byte),
        .i_file_length (r_file_length),
        .i_max_width   (r_max_width),
        .i_max_height  (r_max_height),
        .o_result      (w_result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_result.valid) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result.valid) begin
            r_status <= w_result.status;
            r_width  <= w_result.width;
            r_height <= w_result.height;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_width     = r_width;
    assign o_height    = r_height;

    // A result can only come from an accepted byte
    a_result_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_result.valid |-> in_accept)
        else $error("result raised without an accepted item");

    // A fresh result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !w_result.valid)
        else $error("pending result overwritten");

    // Size is reported only with ok or too-large, and is then non-zero
    a_size_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (((o_status == ST_OK || o_status == ST_TOO_LARGE) &&
                          o_width != '0 && o_height != '0) ||
                         (o_status != ST_OK && o_status != ST_TOO_LARGE &&
                          o_width == '0 && o_height == '0)))
        else $error("size field inconsistent with status");

    // An ok result never exceeds the configured limits
    a_ok_in_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_result.valid && w_result.status == ST_OK |->
            (w_result.width <= r_max_width && w_result.height <= r_max_height))
        else $error("ok result beyond size limits");

endmodule
`default_nettype wire

// File: test/jpeg_frame_header_scanner_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JPEG frame header scanner - testbench
// Streams whole JPEG files byte by byte through the scanner and checks the
// one report each file produces against a cycle-free scanner written here.
// Directed files cover the start marker, marker skipping, segment lengths,
// non-baseline frames, missing headers and the size limits; random files,
// mostly well formed with some noise and corruption, follow. Both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module jpeg_frame_header_scanner_tb;
    import jfhs_pkg::*;

    localparam int unsigned MAX_BYTES    = JFH_MAX_FILE_BYTES;
    localparam int unsigned RANDOM_BYTES = 480;

    // Markers the block has no special name for
    localparam logic [7:0] MK_SOF1 = 8'hC1;
    localparam logic [7:0] MK_APP0 = 8'hE0;
    localparam logic [7:0] MK_DQT  = 8'hDB;
    localparam logic [7:0] MK_DRI  = 8'hDD;
    localparam logic [7:0] MK_COM  = 8'hFE;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
    } t_frame_report;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [FILE_LEN_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic [7:0]            i_data_byte = '0;
    logic                  i_out_ready = 1'b0;
    logic                  o_cfg_ready;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [STATUS_W-1:0]   o_status;
    logic [DIM_W-1:0]      o_width;
    logic [DIM_W-1:0]      o_height;

    // Scanner prediction state and register copies
    t_phase            scan_phase   = PH_START0;
    int unsigned       scan_pos     = 0;
    logic [15:0]       seg_left     = '0;
    logic [15:0]       seg_len      = '0;
    logic [7:0]        marker_seen  = '0;
    logic [15:0]       hgt_seen     = '0;
    logic [15:0]       wid_seen     = '0;
    bit                verdict_given = 1'b0;
    int unsigned       len_latched  = 0;
    int unsigned       lim_file_len = RST_FILE_LENGTH;
    logic [15:0]       lim_w        = RST_MAX_WIDTH;
    logic [15:0]       lim_h        = RST_MAX_HEIGHT;

    t_frame_report     expected_reports[$];
    t_frame_report     head_report;
    logic [7:0]        file_buf[$];
    int unsigned       mismatch_count = 0;
    bit                gaps_on     = 1'b1;
    bit                sink_stalls = 1'b1;
    int unsigned       sink_hold   = 0;

    jpeg_frame_header_scanner #(
        .MAX_FILE_BYTES(MAX_BYTES)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_width     (o_width),
        .o_height    (o_height)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Scanner prediction
    // ------------------------------------------------------------------------
    function automatic bit frame_marker(input logic [7:0] mk);
        return (mk[7:4] == MK_SOF0[7:4]) && !(mk inside {MK_DHT, MK_JPG, MK_DAC});
    endfunction

    function automatic void post_report(input logic [STATUS_W-1:0] st,
                                        input logic [15:0] w, input logic [15:0] h);
        t_frame_report r;
        r.status = st;
        r.width  = w;
        r.height = h;
        expected_reports.push_back(r);
        verdict_given = 1'b1;
        scan_phase    = PH_DRAIN;
    endfunction

    function automatic void advance_scanner(input logic [7:0] b);
        int unsigned room;
        if (scan_pos == 0)
            len_latched = (lim_file_len > MAX_BYTES) ? MAX_BYTES : lim_file_len;
        case (scan_phase)
            PH_START0: begin
                if (len_latched < 4 || b != MK_FILL)
                    post_report(ST_NOT_JPEG, '0, '0);
                else
                    scan_phase = PH_START1;
            end
            PH_START1: begin
                if (b != MK_SOI)
                    post_report(ST_NOT_JPEG, '0, '0);
                else
                    scan_phase = PH_SEEK;
            end
            PH_SEEK: begin
                if (b == MK_FILL)
                    scan_phase = PH_FILL;
            end
            PH_FILL: begin
                if (b == MK_FILL) begin
                    // fill byte: stay
                end else if (b == MK_STUFF || b == MK_SOI || (b >= MK_RST0 && b <= MK_RST7)) begin
                    scan_phase = PH_SEEK;
                end else if (b == MK_EOI || b == MK_SOS) begin
                    scan_phase = PH_DRAIN;
                end else begin
                    marker_seen = b;
                    scan_phase  = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                seg_len    = {b, 8'h00};
                scan_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                seg_len[7:0] = b;
                // the length field started one byte back
                room = len_latched - (scan_pos - 1);
                if (seg_len < 2 || seg_len > room) begin
                    post_report(ST_BAD_LENGTH, '0, '0);
                end else if (frame_marker(marker_seen)) begin
                    if (marker_seen != MK_SOF0)
                        post_report(ST_NOT_BASELINE, '0, '0);
                    else if (seg_len < 8)
                        post_report(ST_BAD_LENGTH, '0, '0);
                    else
                        scan_phase = PH_PREC;
                end else begin
                    seg_left   = seg_len - 16'd2;
                    scan_phase = (seg_left == 0) ? PH_SEEK : PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (seg_left > 0)
                    seg_left = seg_left - 16'd1;
                if (seg_left == 0)
                    scan_phase = PH_SEEK;
            end
            PH_PREC: scan_phase = PH_H_HI;
            PH_H_HI: begin
                hgt_seen   = {b, 8'h00};
                scan_phase = PH_H_LO;
            end
            PH_H_LO: begin
                hgt_seen[7:0] = b;
                scan_phase    = PH_W_HI;
            end
            PH_W_HI: begin
                wid_seen   = {b, 8'h00};
                scan_phase = PH_W_LO;
            end
            PH_W_LO: begin
                wid_seen[7:0] = b;
                if (wid_seen == 0 || hgt_seen == 0)
                    post_report(ST_BAD_LENGTH, '0, '0);
                else if (wid_seen > lim_w || hgt_seen > lim_h)
                    post_report(ST_TOO_LARGE, wid_seen, hgt_seen);
                else
                    post_report(ST_OK, wid_seen, hgt_seen);
            end
            default: ;
        endcase
        if (scan_pos + 1 >= len_latched) begin
            if (!verdict_given)
                post_report(ST_NO_HEADER, '0, '0);
            scan_phase    = PH_START0;
            scan_pos      = 0;
            verdict_given = 1'b0;
        end else begin
            scan_pos++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checking and output back-pressure
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_reports.size() == 0) begin
                flag_mismatch($sformatf("unexpected report: status %0d width %0d height %0d",
                                        o_status, o_width, o_height));
            end else begin
                head_report = expected_reports.pop_front();
                if (o_status !== head_report.status)
                    flag_mismatch($sformatf("status %0d, expected %0d",
                                            o_status, head_report.status));
                if (o_width !== head_report.width)
                    flag_mismatch($sformatf("width %0d, expected %0d",
                                            o_width, head_report.width));
                if (o_height !== head_report.height)
                    flag_mismatch($sformatf("height %0d, expected %0d",
                                            o_height, head_report.height));
            end
        end
        if (sink_hold != 0) begin
            sink_hold--;
            i_out_ready <= 1'b0;
        end else if (!sink_stalls) begin
            i_out_ready <= 1'b1;
        end else begin
            case ($urandom_range(0, 99)) inside
                [0:2]: begin
                    sink_hold   = $urandom_range(10, 40);
                    i_out_ready <= 1'b0;
                end
                [3:29]:  i_out_ready <= 1'b0;
                default: i_out_ready <= 1'b1;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Leave valid high across back-to-back items; drop it only for a gap
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        advance_scanner(b);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [FILE_LEN_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FILE_LENGTH: lim_file_len = value;
            CFG_MAX_WIDTH:   lim_w        = value[DIM_W-1:0];
            CFG_MAX_HEIGHT:  lim_h        = value[DIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic cfg_release();
        i_cfg_valid <= 1'b0;
    endtask

    // Hold until every report is in and the scanner has settled
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_limits(input int unsigned w, input int unsigned h);
        wait_idle();
        cfg_write(CFG_MAX_WIDTH, w[FILE_LEN_W-1:0]);
        cfg_write(CFG_MAX_HEIGHT, h[FILE_LEN_W-1:0]);
        cfg_release();
    endtask

    // Send the file buffer as one file of len_reg bytes (one byte if len_reg is
    // zero), padding with random bytes or cutting it short as needed
    task automatic stream_file(input int unsigned len_reg);
        int unsigned n;
        n = (len_reg == 0) ? 1 : len_reg;
        wait_idle();
        cfg_write(CFG_FILE_LENGTH, len_reg[FILE_LEN_W-1:0]);
        cfg_release();
        for (int unsigned i = 0; i < n; i++)
            send_byte(i < file_buf.size() ? file_buf[i] : 8'($urandom_range(0, 255)));
        file_buf.delete();
    endtask

    // ------------------------------------------------------------------------
    // File building
    // ------------------------------------------------------------------------
    function automatic void put_soi();
        file_buf.push_back(MK_FILL);
        file_buf.push_back(MK_SOI);
    endfunction

    function automatic void put_marker(input logic [7:0] mk);
        file_buf.push_back(MK_FILL);
        file_buf.push_back(mk);
    endfunction

    function automatic void put_segment(input logic [7:0] mk, input int unsigned len_field,
                                        input int unsigned body);
        put_marker(mk);
        file_buf.push_back(len_field[15:8]);
        file_buf.push_back(len_field[7:0]);
        repeat (body) file_buf.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Frame header with one component; a length field of 11 is consistent
    function automatic void put_frame(input logic [7:0] mk, input int unsigned len_field,
                                      input int unsigned h, input int unsigned w);
        put_segment(mk, len_field, 0);
        file_buf.push_back(8'd8);
        file_buf.push_back(h[15:8]);
        file_buf.push_back(h[7:0]);
        file_buf.push_back(w[15:8]);
        file_buf.push_back(w[7:0]);
        file_buf.push_back(8'd1);
        file_buf.push_back(8'd1);
        file_buf.push_back(8'h11);
        file_buf.push_back(8'd0);
    endfunction

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------
    task automatic test_default_limits();
        put_soi();
        put_frame(MK_SOF0, 11, 320, 320);
        stream_file(file_buf.size());
        put_soi();
        put_frame(MK_SOF0, 11, 320, 321);
        stream_file(file_buf.size());
    endtask

    task automatic test_start_marker();
        file_buf.push_back(MK_SOI);
        file_buf.push_back(MK_FILL);
        stream_file(6);
        file_buf.push_back(MK_FILL);
        file_buf.push_back(MK_STUFF);
        stream_file(6);
        // short files fail on the first byte even with a good start marker
        put_soi();
        stream_file(3);
        put_soi();
        stream_file(1);
        put_soi();
        stream_file(0);
        // all ones in the length register; the next write overrides it
        wait_idle();
        cfg_write(CFG_FILE_LENGTH, '1);
        cfg_write(CFG_FILE_LENGTH, MAX_BYTES[FILE_LEN_W-1:0]);
        cfg_release();
        put_soi();
        put_marker(MK_EOI);
        stream_file(4);
    endtask

    task automatic test_marker_skipping();
        put_soi();
        file_buf.push_back(MK_FILL);
        file_buf.push_back(MK_FILL);
        put_marker(MK_STUFF);
        file_buf.push_back(8'h12);
        put_marker(MK_RST0);
        put_marker(MK_RST7);
        put_marker(MK_SOI);
        put_segment(MK_APP0, 2, 0);
        put_segment(MK_DHT, 5, 3);
        put_segment(MK_JPG, 3, 1);
        put_segment(MK_DAC, 4, 2);
        put_frame(MK_SOF0, 11, 17, 33);
        stream_file(file_buf.size() + 3);
    endtask

    task automatic test_segment_lengths();
        put_soi();
        put_segment(MK_APP0, 0, 0);
        stream_file(12);
        put_soi();
        put_segment(MK_APP0, 1, 0);
        stream_file(12);
        // one past the end of the file, then exactly to the end
        put_soi();
        put_segment(MK_APP0, 9, 7);
        stream_file(12);
        put_soi();
        put_segment(MK_APP0, 8, 6);
        stream_file(12);
        put_soi();
        put_frame(MK_SOF0, 7, 10, 10);
        stream_file(file_buf.size());
        put_soi();
        put_frame(MK_SOF0, 8, 10, 10);
        stream_file(file_buf.size());
    endtask

    task automatic test_non_baseline();
        put_soi();
        put_frame(MK_SOF1, 11, 10, 10);
        stream_file(file_buf.size());
        put_soi();
        put_frame(MK_SOF15, 11, 10, 10);
        stream_file(file_buf.size());
    endtask

    task automatic test_missing_header();
        put_soi();
        put_marker(MK_EOI);
        put_frame(MK_SOF0, 11, 10, 10);
        stream_file(file_buf.size());
        put_soi();
        put_segment(MK_DQT, 4, 2);
        put_marker(MK_SOS);
        put_frame(MK_SOF0, 11, 10, 10);
        stream_file(file_buf.size());
        // file ends inside a segment
        put_soi();
        put_segment(MK_COM, 6, 4);
        stream_file(7);
    endtask

    task automatic test_size_limits();
        put_soi();
        put_frame(MK_SOF0, 11, 10, 0);
        stream_file(file_buf.size());
        put_soi();
        put_frame(MK_SOF0, 11, 0, 10);
        stream_file(file_buf.size());
        set_limits(65535, 65535);
        put_soi();
        put_frame(MK_SOF0, 11, 65535, 65535);
        stream_file(file_buf.size());
        set_limits(1, 1);
        put_soi();
        put_frame(MK_SOF0, 11, 1, 1);
        stream_file(file_buf.size());
        put_soi();
        put_frame(MK_SOF0, 11, 1, 2);
        stream_file(file_buf.size());
        put_soi();
        put_frame(MK_SOF0, 11, 2, 1);
        stream_file(file_buf.size());
        set_limits(1, 65535);
        put_soi();
        put_frame(MK_SOF0, 11, 65535, 1);
        stream_file(file_buf.size());
    endtask

    // ------------------------------------------------------------------------
    // Random files
    // ------------------------------------------------------------------------
    function automatic int unsigned pick_limit();
        case ($urandom_range(0, 5))
            0:       return 1;
            1:       return 65535;
            default: return $urandom_range(1, 1024);
        endcase
    endfunction

    function automatic int unsigned pick_dim(input int unsigned limit);
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(0, 65535);
            2:       return (limit < 65535) ? limit + 1 : limit;
            3:       return limit;
            default: return $urandom_range(1, limit);
        endcase
    endfunction

    function automatic logic [7:0] pick_table_marker();
        case ($urandom_range(0, 6))
            0:       return MK_DQT;
            1:       return MK_DHT;
            2:       return MK_DRI;
            3:       return MK_COM;
            4:       return ($urandom_range(0, 1) != 0) ? MK_JPG : MK_DAC;
            default: return MK_APP0 + 8'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic test_random_files();
        int unsigned sent;
        int unsigned kind;
        int unsigned body;
        int unsigned flen;
        logic [7:0]  mk;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 7) == 0)
                set_limits(pick_limit(), pick_limit());
            gaps_on     = $urandom_range(0, 3) != 0;
            sink_stalls = $urandom_range(0, 3) != 0;
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // noise
                repeat ($urandom_range(1, 12)) file_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
                put_soi();
                repeat ($urandom_range(0, 4)) begin
                    case ($urandom_range(0, 6))
                        0: file_buf.push_back(MK_FILL);
                        1: put_marker(MK_STUFF);
                        2: put_marker(MK_RST0 + 8'($urandom_range(0, 7)));
                        3: file_buf.push_back(8'($urandom_range(0, 254)));
                        default: begin
                            body = $urandom_range(0, 6);
                            put_segment(pick_table_marker(), body + 2, body);
                        end
                    endcase
                end
                if ($urandom_range(0, 4) != 0) begin
                    mk = MK_SOF0;
                end else begin
                    do mk = MK_SOF0 + 8'($urandom_range(1, 15));
                    while (!frame_marker(mk));
                end
                put_frame(mk, (kind == 3) ? $urandom_range(0, 14) : 11,
                          pick_dim(lim_h), pick_dim(lim_w));
            end
            // corrupt one byte of a broken file
            if (kind == 1)
                file_buf[$urandom_range(0, file_buf.size() - 1)] = 8'($urandom_range(0, 255));
            if (kind == 2)
                flen = $urandom_range(0, file_buf.size());
            else
                flen = file_buf.size() + $urandom_range(0, 6);
            sent += (flen == 0) ? 1 : flen;
            stream_file(flen);
        end
        gaps_on     = 1'b1;
        sink_stalls = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_limits();
        test_start_marker();
        test_marker_skipping();
        test_segment_lengths();
        test_non_baseline();
        test_missing_header();
        test_size_limits();
        test_random_files();
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("** jpeg_frame_header_scanner: PASSED **");
        else
            $display("** jpeg_frame_header_scanner: FAILED **");
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("** jpeg_frame_header_scanner: FAILED **");
        $finish;
    end

endmodule
